FILE: rtl/core/pidfd_pkg.sv
`default_nettype none
package pidfd_pkg;

   localparam logic signed [31:0] LIMIT_HI = 32'sd26214400;
   localparam logic signed [31:0] LIMIT_LO = -32'sd26214400;
   localparam logic signed [63:0] WIDE_HI = 64'sd1099511627776;
   localparam logic signed [63:0] WIDE_LO = -64'sd1099511627776;

   // beyond this the lag step always drives the state to its limit
   localparam logic signed [47:0] STEP_P_LIM = 48'sd2097152;
   localparam logic        [28:0] STEP_SCALE = 29'd200;
   // ceil(2^32 / 7), exact for dividends below 2^30
   localparam logic        [29:0] RECIP7 = 30'd613566757;

   localparam logic [1:0] REG_GAIN = 2'd0;
   localparam logic [1:0] REG_ITIME = 2'd1;
   localparam logic [1:0] REG_DTIME = 2'd2;
   localparam logic [1:0] REG_FTIME = 2'd3;

   typedef enum logic [3:0] {
      OP_ERR_D, OP_ERR_E, OP_ERR_S, OP_INT_MUL, OP_INT_DIV, OP_INT_UPD,
      OP_DA_MUL, OP_DA_DIV, OP_DB_MUL, OP_DB_DIV, OP_DER_UPD,
      OP_LAG_U, OP_LAG_MUL, OP_LAG_STEP, OP_LAG_UPD, OP_FINISH
   } op_type;

   typedef struct packed {
      logic  load;
      op_type op;
      logic  div_start;
      logic  out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic int_en;
      logic der_en;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] clamp400(input logic signed [65:0] v);
      if (v > 66'(LIMIT_HI)) return LIMIT_HI;
      if (v < 66'(LIMIT_LO)) return LIMIT_LO;
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pidfd_div.sv
`default_nettype none
module pidfd_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic        [30:0] divisor,
   output logic                    busy,
   output logic signed [63:0]      quotient
);
   logic [63:0] mag_ff, mag_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [1:0]  s;
   logic [32:0] trial;
   logic [31:0] r;
   logic [63:0] m;

   // two quotient bits a cycle, restoring
   always_comb begin
      mag_in = mag_ff; rem_in = rem_ff; den_in = den_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      r = rem_ff; m = mag_ff; trial = '0;
      if (start) begin
         neg_in = dividend[63];
         mag_in = dividend[63] ? 64'(-dividend) : 64'(dividend);
         rem_in = '0; den_in = divisor; cnt_in = 6'd31; busy_in = 1'b1;
      end else if (busy_ff) begin
         for (s = 2'd0; s < 2'd2; s++) begin
            trial = {r, m[63]} - {2'b0, den_ff};
            if (!trial[32]) begin
               r = trial[31:0]; m = {m[62:0], 1'b1};
            end else begin
               r = {r[30:0], m[63]}; m = {m[62:0], 1'b0};
            end
         end
         rem_in = r; mag_in = m;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in; rem_ff <= rem_in; den_ff <= den_in; neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
endmodule
`default_nettype wire

FILE: rtl/core/pidfd_ctrl.sv
`default_nettype none
module pidfd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire pidfd_pkg::sts_type sts,
   output pidfd_pkg::cmd_type    cmd
);
   import pidfd_pkg::*;
   localparam logic [1:0] ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_WAIT = 2'd2;
   logic [1:0] state_ff, state_in;
   op_type     op_ff, op_in;
   logic       out_ff, out_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = out_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff;
      out_in = out_ff && !rsp_tready;
      cmd.load = accept; cmd.op = op_ff; cmd.div_start = 1'b0; cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: if (accept) begin state_in = ST_RUN; op_in = OP_ERR_D; end
         ST_RUN: begin
            case (op_ff)
               OP_ERR_D:   op_in = OP_ERR_E;
               OP_ERR_E:   op_in = OP_ERR_S;
               OP_ERR_S:   op_in = sts.int_en ? OP_INT_MUL : (sts.der_en ? OP_DA_MUL : OP_LAG_U);
               OP_INT_MUL: op_in = OP_INT_DIV;
               OP_INT_DIV: begin cmd.div_start = 1'b1; state_in = ST_WAIT; end
               OP_INT_UPD: op_in = sts.der_en ? OP_DA_MUL : OP_LAG_U;
               OP_DA_MUL:  op_in = OP_DA_DIV;
               OP_DA_DIV:  begin cmd.div_start = 1'b1; state_in = ST_WAIT; end
               OP_DB_MUL:  op_in = OP_DB_DIV;
               OP_DB_DIV:  begin cmd.div_start = 1'b1; state_in = ST_WAIT; end
               OP_DER_UPD: op_in = OP_LAG_U;
               OP_LAG_U:   op_in = OP_LAG_MUL;
               OP_LAG_MUL: op_in = OP_LAG_STEP;
               OP_LAG_STEP: op_in = OP_LAG_UPD;
               OP_LAG_UPD: op_in = OP_FINISH;
               OP_FINISH: begin
                  // hold here while the previous beat still sits in the output register
                  if (!out_ff || rsp_tready) begin
                     cmd.out_load = 1'b1; state_in = ST_IDLE; out_in = 1'b1;
                  end
               end
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_WAIT: if (!sts.div_busy) begin
            state_in = ST_RUN;
            case (op_ff)
               OP_INT_DIV: op_in = OP_INT_UPD;
               OP_DA_DIV:  op_in = OP_DB_MUL;
               default:    op_in = OP_DER_UPD;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_WAIT) cmd.op = op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; op_ff <= OP_ERR_D; out_ff <= 1'b0;
      end else begin
         state_ff <= state_in; op_ff <= op_in; out_ff <= out_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/pidfd_dp.sv
`default_nettype none
module pidfd_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pidfd_pkg::cmd_type cmd,
   output pidfd_pkg::sts_type      sts,
   input  wire logic signed [31:0] target,
   input  wire logic signed [31:0] measured,
   input  wire logic        [30:0] time_step,
   input  wire logic signed [31:0] proportional_gain,
   input  wire logic        [30:0] integral_time,
   input  wire logic signed [31:0] derivative_time,
   input  wire logic        [30:0] filter_time,
   output logic signed [25:0]      drive
);
   import pidfd_pkg::*;
   logic signed [31:0] tgt_ff, meas_ff, d_ff, e_ff, c_ff, u_ff;
   logic        [30:0] dt_ff;
   logic signed [63:0] prod_ff, prod_in, a_ff, a_in;
   logic signed [31:0] integ_ff, integ_in, dfilt_ff, dfilt_in;
   logic signed [31:0] lag_ff, lag_in, perr_ff, perr_in;
   logic signed [25:0] drive_ff;
   logic        [28:0] lx_ff, lx_in;
   logic               lneg_ff, lneg_in;
   logic signed [63:0] div_q;
   logic               div_busy;
   logic signed [31:0] e_now;
   logic signed [63:0] b, stepv;
   logic signed [47:0] p, pc;
   logic        [21:0] pmag;
   logic        [58:0] qprod;
   logic        [26:0] q;
   logic        [30:0] div_den;

   assign div_den = (cmd.op == OP_INT_DIV) ? integral_time : filter_time;

   pidfd_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(prod_ff),
      .divisor(div_den), .busy(div_busy), .quotient(div_q)
   );

   assign sts.div_busy = div_busy;
   assign sts.int_en = (integral_time != '0);
   assign sts.der_en = (filter_time != '0);

   assign e_now = sat32(66'($signed(prod_ff[63:16])));

   always_comb begin
      prod_in = prod_ff; a_in = a_ff;
      integ_in = integ_ff; dfilt_in = dfilt_ff; lag_in = lag_ff; perr_in = perr_ff;
      lx_in = lx_ff; lneg_in = lneg_ff;
      b = '0; p = '0; pc = '0; pmag = '0; qprod = '0; q = '0; stepv = '0;
      if (!cmd.load) begin
         case (cmd.op)
            OP_ERR_E:   prod_in = 64'(proportional_gain) * 64'(d_ff);
            OP_INT_MUL: prod_in = $signed({33'b0, dt_ff}) * 64'(e_ff);
            OP_INT_UPD: integ_in = clamp400(66'(integ_ff) + 66'(div_q));
            OP_DA_MUL:  prod_in = 64'(dfilt_ff) * $signed({33'b0, dt_ff});
            OP_DB_MUL: begin
               a_in = (div_q > WIDE_HI) ? WIDE_HI : ((div_q < WIDE_LO) ? WIDE_LO : div_q);
               prod_in = 64'(c_ff) * 64'(derivative_time);
            end
            OP_DER_UPD: begin
               b = (div_q > WIDE_HI) ? WIDE_HI : ((div_q < WIDE_LO) ? WIDE_LO : div_q);
               dfilt_in = sat32(66'(dfilt_ff) - 66'(a_ff) + 66'(b));
            end
            OP_LAG_MUL: prod_in = $signed({33'b0, dt_ff}) * (64'(u_ff) - 64'(lag_ff));
            OP_LAG_STEP: begin
               p = $signed(prod_ff[63:16]);
               pc = (p > STEP_P_LIM) ? STEP_P_LIM : ((p < -STEP_P_LIM) ? -STEP_P_LIM : p);
               pmag = pc[47] ? 22'(-pc) : 22'(pc);
               lx_in = 29'(pmag) * STEP_SCALE;
               lneg_in = pc[47];
            end
            OP_LAG_UPD: begin
               // divide by 7 with truncation toward zero
               qprod = 59'(lx_ff) * 59'(RECIP7);
               q = qprod[58:32];
               stepv = lneg_ff ? -64'(q) : 64'(q);
               lag_in = clamp400(66'(lag_ff) + 66'(stepv));
            end
            OP_FINISH: perr_in = e_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tgt_ff <= target; meas_ff <= measured; dt_ff <= time_step;
      end
      if (cmd.op == OP_ERR_D && !cmd.load)
         d_ff <= sat32(66'(tgt_ff) - 66'(meas_ff));
      if (cmd.op == OP_ERR_S && !cmd.load) begin
         e_ff <= e_now;
         c_ff <= sat32(66'(e_now) - 66'(perr_ff));
      end
      if (cmd.op == OP_LAG_U && !cmd.load)
         u_ff <= sat32(66'(e_ff) + 66'(integ_ff) + 66'(dfilt_ff));
      prod_ff <= prod_in; a_ff <= a_in; lx_ff <= lx_in; lneg_ff <= lneg_in;
      if (reset) begin
         integ_ff <= '0; dfilt_ff <= '0; lag_ff <= '0; perr_ff <= '0; drive_ff <= '0;
      end else begin
         integ_ff <= integ_in; dfilt_ff <= dfilt_in; lag_ff <= lag_in; perr_ff <= perr_in;
         if (cmd.out_load) drive_ff <= lag_ff[25:0];
      end
   end

   assign drive = drive_ff;
endmodule
`default_nettype wire

FILE: rtl/core/pid_filtered_derivative_lag.sv
// the integral step runs only with a nonzero integral time, and the derivative
// steps, with their two divisions, run only with a nonzero filter time
// each division runs on the shared radix-4 divider
// a new beat is taken only once the last one is through the datapath;
// the next beat is accepted while a result waits in the output register
// reset clears the controller and filter state, the csr settings, the drive and the result valid
`default_nettype none
module pid_filtered_derivative_lag (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // target, measured, time_step, pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // drive, pad
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import pidfd_pkg::*;
   logic signed [31:0] gain_ff, dtime_ff;
   logic        [30:0] itime_ff, ftime_ff;
   logic signed [25:0] drive;
   cmd_type cmd;
   sts_type sts;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0; itime_ff <= '0; dtime_ff <= '0; ftime_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         case (csr_paddr[3:2])
            REG_GAIN:  gain_ff <= csr_pwdata;
            REG_ITIME: itime_ff <= csr_pwdata[30:0];
            REG_DTIME: dtime_ff <= csr_pwdata;
            REG_FTIME: ftime_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_GAIN:  csr_prdata = gain_ff;
         REG_ITIME: csr_prdata = {1'b0, itime_ff};
         REG_DTIME: csr_prdata = dtime_ff;
         REG_FTIME: csr_prdata = {1'b0, ftime_ff};
         default:   csr_prdata = '0;
      endcase
   end

   pidfd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .sts(sts), .cmd(cmd)
   );

   pidfd_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .target(req_tdata[31:0]), .measured(req_tdata[63:32]), .time_step(req_tdata[94:64]),
      .proportional_gain(gain_ff), .integral_time(itime_ff),
      .derivative_time(dtime_ff), .filter_time(ftime_ff), .drive(drive)
   );

   assign rsp_tdata = {6'b0, drive};
endmodule
`default_nettype wire
